@@ src/rsas_pkg.sv @@
// ----------------------------------------------------------------------------
// rsas_pkg
// Shared codes and types for the rotated sorted array search block.
// ----------------------------------------------------------------------------
`default_nettype none

package rsas_pkg;

  // Width of the value fields on the input channel
  localparam int FIELD_W = 32;
  // Width of the reported position
  localparam int POS_W   = 10;

  // Item kind codes
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Control part of one queued operation
  typedef struct packed {
    logic is_query;
    logic first;
  } op_ctl_t;

  localparam int OP_CTL_W = $bits(op_ctl_t);

endpackage

`default_nettype wire

@@ src/rsas_fifo.sv @@
// ----------------------------------------------------------------------------
// rsas_fifo
// Two-entry queue that decouples the front stage from the search engine.
// ----------------------------------------------------------------------------
`default_nettype none

module rsas_fifo #(
  parameter int W = 34
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push_valid,
  output logic              push_ready,
  input  wire logic [W-1:0] push_data,
  output logic              pop_valid,
  input  wire logic         pop_ready,
  output logic [W-1:0]      pop_data
);

  logic [W-1:0] entry_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   fill_r;
  logic         do_push;
  logic         do_pop;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      if (do_push && !do_pop)      fill_r <= fill_r + 2'd1;
      else if (do_pop && !do_push) fill_r <= fill_r - 2'd1;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

@@ src/rsas_front.sv @@
// ----------------------------------------------------------------------------
// rsas_front
// Accepts input transactions, classifies them and brings the value to the
// internal data width, then hands them to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rsas_front #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_kind,
  input  wire logic                             in_first,
  input  wire logic signed [rsas_pkg::FIELD_W-1:0] in_elem_value,
  input  wire logic signed [rsas_pkg::FIELD_W-1:0] in_target,
  output logic                                  op_valid,
  input  wire logic                             op_ready,
  output rsas_pkg::op_ctl_t                     op_ctl,
  output logic [DATA_WIDTH-1:0]                 op_value
);

  import rsas_pkg::*;

  logic                          valid_r;
  op_ctl_t                       ctl_r;
  logic [DATA_WIDTH-1:0]         value_r;
  logic [FIELD_W-1:0]            pick;
  logic [DATA_WIDTH+FIELD_W-1:0] ext;
  logic                          take;

  assign in_ready = !valid_r || op_ready;
  assign take     = in_valid && in_ready;
  assign op_valid = valid_r;
  assign op_ctl   = ctl_r;
  assign op_value = value_r;

  // select the operand, sign extend, keep the low DATA_WIDTH bits
  assign pick = (in_kind == KIND_QUERY) ? in_target : in_elem_value;
  assign ext  = {{DATA_WIDTH{pick[FIELD_W-1]}}, pick};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (op_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ctl_r.is_query <= (in_kind == KIND_QUERY);
      ctl_r.first    <= in_first;
      value_r        <= ext[DATA_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

@@ src/rsas_back.sv @@
// ----------------------------------------------------------------------------
// rsas_back
// Element store and search engine: performs loads and runs the rotated
// binary search for queries, with a result register on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module rsas_back #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int DATA_WIDTH   = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          op_valid,
  output logic                               op_ready,
  input  wire rsas_pkg::op_ctl_t             op_ctl,
  input  wire logic [DATA_WIDTH-1:0]         op_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_found,
  output logic [rsas_pkg::POS_W-1:0]         out_position
);

  import rsas_pkg::*;

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MID,
    S_EDGE,
    S_DONE
  } state_t;

  typedef logic signed [CW:0] bound_t;

  state_t                       state_r;
  logic [CW-1:0]                count_r;
  bound_t                       lo_r;
  bound_t                       hi_r;
  logic [AW-1:0]                mid_r;
  logic signed [DATA_WIDTH-1:0] t_r;
  logic signed [DATA_WIDTH-1:0] vm_r;
  logic                         vm_lt_r;
  logic                         found_r;
  logic                         out_valid_r;
  logic                         out_found_r;
  logic [POS_W-1:0]             out_pos_r;

  logic [DATA_WIDTH-1:0]        mem [MAX_ELEMENTS];
  logic signed [DATA_WIDTH-1:0] rd_data_r;
  logic [AW-1:0]                rd_addr;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;

  bound_t                       diff;
  bound_t                       mid_nxt;
  bound_t                       mid_ext;
  bound_t                       mid_inc;
  bound_t                       mid_dec;
  logic                         not_full;
  logic                         load_go;
  logic                         query_go;
  logic                         vm_eq;
  logic                         vm_lt;
  logic                         go_low;
  logic [AW+POS_W-1:0]          pos_ext;

  assign op_ready  = (state_r == S_IDLE);
  assign load_go   = op_valid && op_ready && !op_ctl.is_query;
  assign query_go  = op_valid && op_ready && op_ctl.is_query;
  assign not_full  = (count_r < CW'(MAX_ELEMENTS));

  // store write: a restart always lands at index zero
  assign wr_en   = load_go && (op_ctl.first || not_full);
  assign wr_addr = op_ctl.first ? '0 : count_r[AW-1:0];

  // midpoint of the current window
  assign diff    = hi_r - lo_r;
  assign mid_nxt = lo_r + (diff >>> 1);
  assign mid_ext = bound_t'({1'b0, mid_r});
  assign mid_inc = mid_ext + bound_t'(1);
  assign mid_dec = mid_ext - bound_t'(1);

  // middle element against the target
  assign vm_eq = (rd_data_r == t_r);
  assign vm_lt = (rd_data_r < t_r);

  // edge check: true when the search continues in the lower half
  always_comb begin
    if (vm_lt_r) begin
      go_low = (vm_r <= rd_data_r) && (t_r > rd_data_r);
    end else begin
      go_low = !((vm_r >= rd_data_r) && (t_r < rd_data_r));
    end
  end

  // read address: midpoint, then the end or the start of the window
  always_comb begin
    case (state_r)
      S_CHECK: rd_addr = mid_nxt[AW-1:0];
      S_MID:   rd_addr = vm_lt ? hi_r[AW-1:0] : lo_r[AW-1:0];
      default: rd_addr = mid_r;
    endcase
  end

  // element store
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= op_value;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign pos_ext = {{POS_W{1'b0}}, mid_r};

  // search sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_DONE)) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (load_go) begin
            if (op_ctl.first)  count_r <= CW'(1);
            else if (not_full) count_r <= count_r + CW'(1);
          end
          if (query_go) begin
            t_r     <= op_value;
            lo_r    <= '0;
            hi_r    <= bound_t'({1'b0, count_r}) - bound_t'(1);
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (lo_r > hi_r) begin
            found_r <= 1'b0;
            state_r <= S_DONE;
          end else begin
            mid_r   <= mid_nxt[AW-1:0];
            state_r <= S_MID;
          end
        end
        S_MID: begin
          vm_r    <= rd_data_r;
          vm_lt_r <= vm_lt;
          if (vm_eq) begin
            found_r <= 1'b1;
            state_r <= S_DONE;
          end else begin
            state_r <= S_EDGE;
          end
        end
        S_EDGE: begin
          if (go_low) hi_r <= mid_dec;
          else        lo_r <= mid_inc;
          state_r <= S_CHECK;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_found_r <= found_r;
            out_pos_r   <= found_r ? pos_ext[POS_W-1:0] : '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_pos_r;

endmodule

`default_nettype wire

@@ src/rotated_sorted_array_search.sv @@
// ----------------------------------------------------------------------------
// rotated_sorted_array_search
// Search in an ascending array rotated at an unknown pivot: loads append
// elements to an on-chip store, queries run a binary search for a target.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    kind, first, elem_value, target
//   out_     output     out_valid/out_ready  found, position
//
// Loads are taken at one per cycle while the engine is idle. A query runs
// search steps, each a midpoint read, an edge read and a window update on
// the single read port of the store, and then registers its result; the
// engine takes no new item until that result is in the output register.
// Reset clears the element count and all handshake state; the store is not
// cleared. A two-entry queue sits between the input stage and the engine, so
// input is taken while a result waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rotated_sorted_array_search #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int DATA_WIDTH   = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_kind,
  input  wire logic                                in_first,
  input  wire logic signed [rsas_pkg::FIELD_W-1:0] in_elem_value,
  input  wire logic signed [rsas_pkg::FIELD_W-1:0] in_target,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_found,
  output logic [rsas_pkg::POS_W-1:0]               out_position
);

  import rsas_pkg::*;

  localparam int QW = OP_CTL_W + DATA_WIDTH;

  logic                  f_valid;
  logic                  f_ready;
  op_ctl_t               f_ctl;
  logic [DATA_WIDTH-1:0] f_value;
  logic                  q_valid;
  logic                  q_ready;
  logic [QW-1:0]         q_data;
  op_ctl_t               q_ctl;

  assign q_ctl = op_ctl_t'(q_data[QW-1 -: OP_CTL_W]);

  // input stage
  rsas_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_first      (in_first),
    .in_elem_value (in_elem_value),
    .in_target     (in_target),
    .op_valid      (f_valid),
    .op_ready      (f_ready),
    .op_ctl        (f_ctl),
    .op_value      (f_value)
  );

  // decoupling queue
  rsas_fifo #(
    .W (QW)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_ctl, f_value}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // store and search engine
  rsas_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .op_valid     (q_valid),
    .op_ready     (q_ready),
    .op_ctl       (q_ctl),
    .op_value     (q_data[DATA_WIDTH-1:0]),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_found    (out_found),
    .out_position (out_position)
  );

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench for rotated_sorted_array_search. A short stimulus table covers the
// empty array, single-element and rotated arrays with the value extremes,
// missing targets and out-of-order data. A capacity fill follows, with loads
// past the end. Random arrays come last: mostly rotated ascending sets of
// random size and spread, with some unsorted data, duplicates and appends.
// Every query transaction is checked against an internal search model or a
// typed expectation, and both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rsas_pkg::*;

  localparam int DEPTH        = 1024;
  localparam int ITEM_BUDGET  = 1150;
  localparam int DRAIN_CYCLES = 50;

  localparam logic signed [FIELD_W-1:0] VAL_MIN = {1'b1, {(FIELD_W-1){1'b0}}};
  localparam logic signed [FIELD_W-1:0] VAL_MAX = {1'b0, {(FIELD_W-1){1'b1}}};

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } search_res_t;

  typedef struct packed {
    logic                      kind;
    logic                      first;
    logic signed [FIELD_W-1:0] value;
    logic signed [FIELD_W-1:0] target;
    logic                      typed;
    search_res_t               res;
  } stim_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_kind;
  logic                      in_first;
  logic signed [FIELD_W-1:0] in_elem_value;
  logic signed [FIELD_W-1:0] in_target;
  logic                      out_valid;
  logic                      out_ready;
  logic                      out_found;
  logic [POS_W-1:0]          out_position;

  // Model of the element store and its fill level
  logic signed [FIELD_W-1:0] elem_mem [DEPTH];
  int unsigned               elem_cnt = 0;

  // Current random set (sorted order) and its rotation
  logic signed [FIELD_W-1:0] set_vals [DEPTH];
  int unsigned               set_n = 1;
  int unsigned               rot_shift = 0;

  search_res_t pending_results [$];
  int unsigned items_sent = 0;
  int unsigned fail_count = 0;
  bit          no_gaps = 1'b0;

  // Directed table: expected results typed in only where obvious
  stim_row_t dir_rows [23] = '{
    // queries on the empty array right after reset
    '{KIND_QUERY, 1'b0, 32'sd0,   32'sd0,   1'b1, '{1'b0, 10'd0}},
    '{KIND_QUERY, 1'b1, VAL_MAX,  VAL_MAX,  1'b1, '{1'b0, 10'd0}},
    // one element: hit and miss
    '{KIND_LOAD,  1'b1, 32'sd5,   32'sd0,   1'b0, '0},
    '{KIND_QUERY, 1'b0, 32'sd0,   32'sd5,   1'b1, '{1'b1, 10'd0}},
    '{KIND_QUERY, 1'b0, 32'sd0,   32'sd4,   1'b1, '{1'b0, 10'd0}},
    // restart with a rotated array that wraps through both extremes
    '{KIND_LOAD,  1'b1, 32'sd40,  32'sd0,   1'b0, '0},
    '{KIND_LOAD,  1'b0, 32'sd100, 32'sd0,   1'b0, '0},
    '{KIND_LOAD,  1'b0, VAL_MAX,  32'sd0,   1'b0, '0},
    '{KIND_LOAD,  1'b0, VAL_MIN,  32'sd0,   1'b0, '0},
    '{KIND_LOAD,  1'b0, -32'sd7,  32'sd0,   1'b0, '0},
    '{KIND_LOAD,  1'b0, 32'sd0,   32'sd0,   1'b0, '0},
    '{KIND_LOAD,  1'b0, 32'sd3,   32'sd0,   1'b0, '0},
    '{KIND_QUERY, 1'b0, 32'sd0,   VAL_MIN,  1'b1, '{1'b1, 10'd3}},
    '{KIND_QUERY, 1'b0, 32'sd0,   VAL_MAX,  1'b1, '{1'b1, 10'd2}},
    '{KIND_QUERY, 1'b0, 32'sd0,   32'sd3,   1'b1, '{1'b1, 10'd6}},
    '{KIND_QUERY, 1'b0, 32'sd0,   32'sd41,  1'b1, '{1'b0, 10'd0}},
    // first flag on a query must not restart the array
    '{KIND_QUERY, 1'b1, 32'sd0,   32'sd100, 1'b1, '{1'b1, 10'd1}},
    // append a duplicate out of order
    '{KIND_LOAD,  1'b0, -32'sd7,  32'sd0,   1'b0, '0},
    '{KIND_QUERY, 1'b0, 32'sd0,   -32'sd7,  1'b0, '0},
    '{KIND_QUERY, 1'b0, 32'sd0,   -32'sd8,  1'b0, '0},
    // all-ones value, repeated
    '{KIND_LOAD,  1'b1, -32'sd1,  32'sd0,   1'b0, '0},
    '{KIND_LOAD,  1'b0, -32'sd1,  32'sd0,   1'b0, '0},
    '{KIND_QUERY, 1'b0, 32'sd0,   -32'sd1,  1'b0, '0}
  };

  rotated_sorted_array_search DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_first      (in_first),
    .in_elem_value (in_elem_value),
    .in_target     (in_target),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_found     (out_found),
    .out_position  (out_position)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Idle length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Send one transaction, then update the model and queue any search result
  task automatic drive_item(input logic kind, input logic first,
                            input logic signed [FIELD_W-1:0] value,
                            input logic signed [FIELD_W-1:0] target,
                            input logic typed, input search_res_t typed_res);
    int unsigned               idle;
    int                        lo;
    int                        hi;
    int                        mid;
    logic signed [FIELD_W-1:0] mid_v;
    logic signed [FIELD_W-1:0] edge_v;
    search_res_t               res;
    idle = no_gaps ? 0 : pick_gap();
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_first      <= first;
    in_elem_value <= value;
    in_target     <= target;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;

    if (kind == KIND_LOAD) begin
      if (first) elem_cnt = 0;
      // loads past capacity are dropped
      if (elem_cnt < DEPTH) begin
        elem_mem[elem_cnt] = value;
        elem_cnt++;
      end
    end else begin
      // binary search; the half to keep is picked against the end or start
      res = '0;
      lo  = 0;
      hi  = int'(elem_cnt) - 1;
      while (!res.found && lo <= hi) begin
        mid   = lo + (hi - lo) / 2;
        mid_v = elem_mem[mid];
        if (mid_v == target) begin
          res.found    = 1'b1;
          res.position = mid[POS_W-1:0];
        end else if (mid_v < target) begin
          edge_v = elem_mem[hi];
          if (mid_v <= edge_v && target > edge_v) hi = mid - 1;
          else lo = mid + 1;
        end else begin
          edge_v = elem_mem[lo];
          if (mid_v >= edge_v && target < edge_v) lo = mid + 1;
          else hi = mid - 1;
        end
      end
      pending_results.push_back(typed ? typed_res : res);
    end
  endtask

  // Fill set_vals with n unique ascending values, tight or spread wide
  task automatic gen_sorted(input int unsigned n, input bit tight);
    longint step_cap;
    longint v;
    if (tight) begin
      step_cap = $urandom_range(4, 1);
      v = -64'sd2147483648 +
          (longint'($urandom) % (64'sd4294967296 - step_cap * n));
    end else begin
      step_cap = (64'sd4294967295 - n) / n;
      v = -64'sd2147483648 + (longint'($urandom) % step_cap);
    end
    for (int unsigned i = 0; i < n; i++) begin
      set_vals[i] = v[FIELD_W-1:0];
      v = v + 1 + (longint'($urandom) % step_cap);
    end
    set_n = n;
  endtask

  // Load set_vals rotated by a random amount, restarting the array
  task automatic load_rotated(input int unsigned n);
    rot_shift = $urandom_range(n - 1);
    for (int unsigned i = 0; i < n; i++)
      drive_item(KIND_LOAD, i == 0, set_vals[(i + rot_shift) % n], $urandom,
                 1'b0, '0);
  endtask

  // Queries: mostly present values, some neighbors, extremes and noise
  task automatic query_set(input int unsigned qn);
    int unsigned               r;
    logic signed [FIELD_W-1:0] key;
    repeat (qn) begin
      r = $urandom_range(99);
      if (r < 60) key = set_vals[$urandom_range(set_n - 1)];
      else if (r < 80) key = set_vals[$urandom_range(set_n - 1)] + 1;
      else if (r < 90) begin
        case ($urandom_range(3))
          0:       key = VAL_MIN;
          1:       key = VAL_MAX;
          2:       key = '0;
          default: key = '1;
        endcase
      end else key = $urandom;
      drive_item(KIND_QUERY, 1'($urandom_range(1)), $urandom, key, 1'b0, '0);
    end
  endtask

  // Result side: ready stretches broken by stalls of random length
  initial begin : out_pacing
    int unsigned run;
    int unsigned hold;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      run  = $urandom_range(40, 1);
      hold = pick_gap();
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : result_check
    search_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got found %0b position %0d",
                 $time, out_found, out_position);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_found !== want.found) begin
          $display("%0t: found mismatch, expected %0b, got %0b",
                   $time, want.found, out_found);
          fail_count++;
        end
        if (out_position !== want.position) begin
          $display("%0t: position mismatch, expected %0d, got %0d",
                   $time, want.position, out_position);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned sel;
    int unsigned r;
    int unsigned n;
    in_valid      <= 1'b0;
    in_kind       <= KIND_LOAD;
    in_first      <= 1'b0;
    in_elem_value <= '0;
    in_target     <= '0;
    rst_n         <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (dir_rows[i])
      drive_item(dir_rows[i].kind, dir_rows[i].first, dir_rows[i].value,
                 dir_rows[i].target, dir_rows[i].typed, dir_rows[i].res);

    // fill to capacity, overflow loads, then search the full array
    gen_sorted(DEPTH, 1'b0);
    load_rotated(DEPTH);
    repeat (3) drive_item(KIND_LOAD, 1'b0, $urandom, $urandom, 1'b0, '0);
    drive_item(KIND_QUERY, 1'b0, $urandom,
               set_vals[(DEPTH - 1 + rot_shift) % DEPTH], 1'b0, '0);
    query_set(12);

    // random sets until the overall item budget is spent
    while (items_sent < ITEM_BUDGET) begin
      no_gaps = ($urandom_range(3) == 0);
      sel = $urandom_range(99);
      if (sel < 80) begin
        // well-formed rotated array, mostly small
        r = $urandom_range(99);
        if (r < 70) n = $urandom_range(16, 1);
        else if (r < 96) n = $urandom_range(100, 17);
        else n = $urandom_range(160, 101);
        gen_sorted(n, 1'($urandom_range(1)));
        load_rotated(n);
        query_set($urandom_range(6, 1));
      end else if (sel < 92) begin
        // unsorted data, often with duplicates from a small pool
        n = $urandom_range(20, 1);
        r = $urandom_range(1);
        for (int unsigned i = 0; i < n; i++)
          set_vals[i] = r ? $urandom : FIELD_W'(int'($urandom_range(8)) - 4);
        set_n = n;
        load_rotated(n);
        query_set($urandom_range(4, 1));
      end else begin
        // append without restart, breaking the order
        repeat ($urandom_range(5, 1))
          drive_item(KIND_LOAD, 1'b0,
                     $urandom_range(1) ? set_vals[$urandom_range(set_n - 1)]
                                       : $urandom,
                     $urandom, 1'b0, '0);
        query_set($urandom_range(4, 1));
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // Hang guard
  initial begin
    #30ms;
    $display("Verification failed");
    $finish;
  end

endmodule
